### src/afcb_pkg.sv
`default_nettype none
package afcb_pkg;

  localparam int DIMS      = 64;
  localparam int ADDR_W    = $clog2(2 * DIMS);
  localparam int SUM_W     = 39;
  localparam int NORM_W    = 20;
  localparam int SCORE_W   = 17;
  localparam int PAIR_W    = 16;
  localparam int ROOT_W    = 40;
  localparam int DEN_W     = 40;
  localparam int REM_W     = 58;
  localparam int QUO_W     = 18;
  localparam int ROOT_STEPS = 20;
  localparam int DIV_STEPS  = 18;
  localparam int CNT_W     = 5;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 17'h10000;
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

  localparam logic CMD_ELEMENT   = 1'b0;
  localparam logic CMD_FRAME_END = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELEM,
    ST_ROOT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic accept;
    logic elem;
    logic root_step;
    logic mul_lo;
    logic mul_hi;
    logic div_load;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

### src/afcb_ctrl.sv
`default_nettype none
module afcb_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  input  wire                  in_tuser,
  output logic                 in_tready,
  input  afcb_pkg::dp_stat_t   stat,
  output afcb_pkg::dp_cmd_t    cmd
);

  afcb_pkg::state_t state_r, state_nxt;
  logic [afcb_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= afcb_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      afcb_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) begin
          state_nxt = (in_tuser == afcb_pkg::CMD_FRAME_END) ? afcb_pkg::ST_ROOT
                                                             : afcb_pkg::ST_ELEM;
        end
      end
      afcb_pkg::ST_ELEM: state_nxt = afcb_pkg::ST_IDLE;
      afcb_pkg::ST_ROOT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == afcb_pkg::CNT_W'(afcb_pkg::ROOT_STEPS - 1)) begin
          state_nxt = afcb_pkg::ST_MUL_LO;
        end
      end
      afcb_pkg::ST_MUL_LO: state_nxt = afcb_pkg::ST_MUL_HI;
      afcb_pkg::ST_MUL_HI: state_nxt = afcb_pkg::ST_DIV_LOAD;
      afcb_pkg::ST_DIV_LOAD: begin
        cnt_nxt   = '0;
        state_nxt = afcb_pkg::ST_DIV;
      end
      afcb_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == afcb_pkg::CNT_W'(afcb_pkg::DIV_STEPS - 1)) begin
          state_nxt = afcb_pkg::ST_DECIDE;
        end
      end
      afcb_pkg::ST_DECIDE: begin
        if (!stat.out_busy) state_nxt = afcb_pkg::ST_IDLE;
      end
      default: state_nxt = afcb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      afcb_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      afcb_pkg::ST_ELEM:     cmd.elem      = 1'b1;
      afcb_pkg::ST_ROOT:     cmd.root_step = 1'b1;
      afcb_pkg::ST_MUL_LO:   cmd.mul_lo    = 1'b1;
      afcb_pkg::ST_MUL_HI:   cmd.mul_hi    = 1'b1;
      afcb_pkg::ST_DIV_LOAD: cmd.div_load  = 1'b1;
      afcb_pkg::ST_DIV:      cmd.div_step  = 1'b1;
      afcb_pkg::ST_DECIDE:   cmd.commit    = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

### src/afcb_dp.sv
`default_nettype none
module afcb_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  afcb_pkg::dp_cmd_t    cmd,
  output afcb_pkg::dp_stat_t   stat,
  input  wire  [5:0]           in_dim,
  input  wire  [15:0]          in_value,
  input  wire                  cfg_we,
  input  wire  [afcb_pkg::SCORE_W-1:0] cfg_thr,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic                 out_boundary,
  output logic [afcb_pkg::SCORE_W-1:0] out_score,
  output logic [afcb_pkg::PAIR_W-1:0]  out_pair
);

  localparam int AW = afcb_pkg::ADDR_W;
  localparam int NE = 2 * afcb_pkg::DIMS;

  logic [15:0] mem [NE];
  logic [15:0] rd_data_r;
  logic        mark_hit_r;
  logic [NE-1:0] marks_r, marks_nxt;

  logic [AW-1:0] d_r;
  logic [15:0]   v_r;
  logic          dim_ok_r;

  logic bank_r;
  logic [afcb_pkg::SUM_W-1:0] dot_r, sq_r, dot_nxt, sq_nxt;
  logic [afcb_pkg::NORM_W-1:0] prev_norm_r;
  logic [afcb_pkg::SCORE_W-1:0] older_r, newer_r, thr_r;
  logic [1:0] seen_r;
  logic [afcb_pkg::PAIR_W-1:0] pair_r;

  logic [afcb_pkg::ROOT_W-1:0] op_r, res_r, one_r;
  logic [afcb_pkg::DEN_W-1:0]  den_r;
  logic [afcb_pkg::REM_W-1:0]  rem_r, ds_r;
  logic [afcb_pkg::QUO_W-1:0]  quo_r;
  logic                        sat_r;

  logic                        out_valid_r, out_b_r;
  logic [afcb_pkg::SCORE_W-1:0] out_score_r;
  logic [afcb_pkg::PAIR_W-1:0]  out_pair_r;

  logic [AW-1:0] rd_addr, wr_addr;
  logic          in_dim_ok;

  assign in_dim_ok = int'(in_dim) < afcb_pkg::DIMS;
  // Bank zero holds entries 0..DIMS-1, bank one the rest.
  assign rd_addr = bank_r ? AW'(in_dim) : AW'(in_dim) + AW'(afcb_pkg::DIMS);
  assign wr_addr = bank_r ? d_r + AW'(afcb_pkg::DIMS) : d_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) rd_data_r <= mem[rd_addr];
    if (cmd.elem && dim_ok_r) mem[wr_addr] <= v_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      d_r        <= AW'(in_dim);
      v_r        <= in_value;
      dim_ok_r   <= in_dim_ok;
      mark_hit_r <= marks_r[rd_addr];
    end
  end

  // Element accumulation.
  logic [31:0] sq_prod, dot_prod;
  logic [afcb_pkg::SUM_W:0] sq_add, dot_add;
  assign sq_prod  = 32'(v_r) * 32'(v_r);
  assign dot_prod = mark_hit_r ? 32'(rd_data_r) * 32'(v_r) : 32'd0;
  assign sq_add   = {1'b0, sq_r} + (afcb_pkg::SUM_W + 1)'(sq_prod);
  assign dot_add  = {1'b0, dot_r} + (afcb_pkg::SUM_W + 1)'(dot_prod);

  always_comb begin
    sq_nxt  = sq_add[afcb_pkg::SUM_W] ? afcb_pkg::SUM_MAX : sq_add[afcb_pkg::SUM_W-1:0];
    dot_nxt = dot_add[afcb_pkg::SUM_W] ? afcb_pkg::SUM_MAX : dot_add[afcb_pkg::SUM_W-1:0];
  end

  // Digit-by-digit square root, one result bit a step.
  logic [afcb_pkg::ROOT_W-1:0] root_sum;
  logic                        root_ge;
  assign root_sum = res_r + one_r;
  assign root_ge  = op_r >= root_sum;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= afcb_pkg::ROOT_W'(sq_r);
      res_r <= '0;
      one_r <= afcb_pkg::ROOT_W'(1) << (2 * (afcb_pkg::ROOT_STEPS - 1));
    end else if (cmd.root_step) begin
      if (root_ge) begin
        op_r  <= op_r - root_sum;
        res_r <= (res_r >> 1) + one_r;
      end else begin
        res_r <= res_r >> 1;
      end
      one_r <= one_r >> 2;
    end
  end

  logic [afcb_pkg::NORM_W-1:0] norm;
  assign norm = res_r[afcb_pkg::NORM_W-1:0];

  // Denominator from two 20x10 partial products.
  logic [9:0]  mul_b;
  logic [29:0] pp;
  assign mul_b = cmd.mul_hi ? norm[19:10] : norm[9:0];
  assign pp    = 30'(prev_norm_r) * 30'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) den_r <= afcb_pkg::DEN_W'(pp);
    else if (cmd.mul_hi) den_r <= den_r + {pp, 10'b0};
  end

  // Restoring division, one quotient bit a step.
  logic [afcb_pkg::REM_W-1:0] num;
  assign num = afcb_pkg::REM_W'({dot_r, 16'b0}) + afcb_pkg::REM_W'(den_r >> 1);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= num;
      ds_r  <= afcb_pkg::REM_W'({den_r, 17'b0});
      sat_r <= num >= {den_r, 18'b0};
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= ds_r) begin
        rem_r <= rem_r - ds_r;
        quo_r <= {quo_r[afcb_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[afcb_pkg::QUO_W-2:0], 1'b0};
      end
      ds_r <= ds_r >> 1;
    end
  end

  // Score and local-minimum decision.
  logic [afcb_pkg::SCORE_W-1:0] score;
  logic                         bnd;
  logic [afcb_pkg::SCORE_W:0]   first_sum;

  always_comb begin
    if (prev_norm_r == '0 || norm == '0) score = '0;
    else if (sat_r || quo_r > afcb_pkg::QUO_W'(afcb_pkg::SCORE_MAX)) score = afcb_pkg::SCORE_MAX;
    else score = quo_r[afcb_pkg::SCORE_W-1:0];
    first_sum = {1'b0, newer_r} + {1'b0, thr_r};
    if (seen_r == 2'd2) begin
      bnd = first_sum < {1'b0, score};
    end else begin
      bnd = (older_r >= newer_r) && (newer_r < score) &&
            (((older_r - newer_r) > thr_r) || ((score - newer_r) > thr_r));
    end
  end

  always_comb begin
    marks_nxt = marks_r;
    if (cmd.elem && dim_ok_r) marks_nxt[wr_addr] = 1'b1;
    if (cmd.commit) begin
      for (int k = 0; k < NE; k++) begin
        // The bank that becomes current starts empty.
        if ((k >= afcb_pkg::DIMS) != bank_r) marks_nxt[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r     <= '0;
      bank_r      <= 1'b0;
      dot_r       <= '0;
      sq_r        <= '0;
      prev_norm_r <= '0;
      older_r     <= '0;
      newer_r     <= '0;
      seen_r      <= '0;
      pair_r      <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      marks_r <= marks_nxt;
      if (cfg_we) thr_r <= cfg_thr;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.elem && dim_ok_r) begin
        dot_r <= dot_nxt;
        sq_r  <= sq_nxt;
      end
      if (cmd.commit) begin
        if (seen_r != 2'd0) begin
          older_r <= newer_r;
          newer_r <= score;
        end
        if (seen_r >= 2'd2) begin
          out_valid_r <= 1'b1;
          pair_r      <= pair_r + 1'b1;
        end
        if (seen_r != 2'd3) seen_r <= seen_r + 1'b1;
        prev_norm_r <= norm;
        bank_r      <= ~bank_r;
        dot_r       <= '0;
        sq_r        <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && seen_r >= 2'd2) begin
      out_b_r     <= bnd;
      out_score_r <= newer_r;
      out_pair_r  <= pair_r;
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_boundary  = out_b_r;
  assign out_score     = out_score_r;
  assign out_pair      = out_pair_r;

endmodule
`default_nettype wire

### src/adjacent_frame_cosine_boundary_unit.sv
`default_nettype none
// Cosine boundary detector over a stream of sparse frames. Each element beat
// passes through a memory read, then a multiply-accumulate. An end-of-frame
// beat runs 20 square-root steps, 2 partial products for the denominator,
// a load and 18 division steps, then a decision step, which waits while an
// earlier result beat is still held on the output.
// From the third frame end on, each frame end yields one result beat that
// judges the score before the newest one.
module adjacent_frame_cosine_boundary_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // dim_index[5:0], value[21:6], zero pad
  input  wire         in_tuser,   // cmd
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // score[16:0], pair_number[32:17], zero pad
  output logic        out_tuser,  // boundary
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [16:0] cfg_data
);

  afcb_pkg::dp_cmd_t  cmd;
  afcb_pkg::dp_stat_t stat;
  logic [afcb_pkg::SCORE_W-1:0] score;
  logic [afcb_pkg::PAIR_W-1:0]  pair;

  assign cfg_ready = 1'b1;

  afcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  afcb_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_dim       (in_tdata[5:0]),
    .in_value     (in_tdata[21:6]),
    .cfg_we       (cfg_valid),
    .cfg_thr      (cfg_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_boundary (out_tuser),
    .out_score    (score),
    .out_pair     (pair)
  );

  assign out_tdata = {7'b0, pair, score};

endmodule
`default_nettype wire

### src/afcb_checker.sv
`default_nettype none
module afcb_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        in_tuser,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_elem_two: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready ##1 !in_tready)
    else $error("frame end finished too early");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result beat right after reset");

endmodule

bind adjacent_frame_cosine_boundary_unit afcb_checker u_afcb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
